FILE: sv/b58_pkg.sv
// shared types, constants and helper functions of the base-58 encoder
package b58_pkg;

  localparam int MAX_BYTES_DEF  = 32;
  localparam int MAX_DIGITS_DEF = 64;
  localparam int OUT_LIMIT      = 64;
  localparam int OUT_LIMIT_W    = $clog2(OUT_LIMIT + 1);

  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int SUM_W   = DIGIT_W + BYTE_W;

  localparam int RADIX       = 58;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + RADIX - 1) / RADIX;
  localparam int RECIP_W     = $clog2(RECIP_MULT + 1);
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [CHAR_W-1:0] CHAR_ONE  = 7'h31;
  localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_FINISH,
    S_FLAG,
    S_ZEROS,
    S_DIGITS
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  quot;
    logic [DIGIT_W-1:0] rem;
  } fold_res_t;

  // maps a base-58 digit to its character, skipping 0, I, O and l
  function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d7;
    d7 = {1'b0, d};
    if (d < 6'd9)       return d7 + 7'h31;
    else if (d < 6'd17) return d7 + 7'h38;
    else if (d < 6'd22) return d7 + 7'h39;
    else if (d < 6'd33) return d7 + 7'h3A;
    else if (d < 6'd44) return d7 + 7'h40;
    else if (d < 6'd58) return d7 + 7'h41;
    else                return CHAR_ONE;
  endfunction

endpackage

FILE: sv/b58_ram.sv
// generic single-write, single-read memory with registered read data
module b58_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/b58_fold_unit.sv
// shared multiply-by-256, add-carry and divide-by-58 step
module b58_fold_unit (
  input  logic [b58_pkg::BYTE_W-1:0]  carry,
  input  logic [b58_pkg::DIGIT_W-1:0] digit,
  input  logic                        use_digit,
  output b58_pkg::fold_res_t          res
);
  import b58_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [BYTE_W-1:0] quot;
  logic [SUM_W-1:0]  quot_ext;
  logic [SUM_W-1:0]  quot_x58;
  logic [SUM_W-1:0]  rem_full;

  // carry is below 256, so digit*256 + carry is a plain concatenation
  assign sum  = use_digit ? {digit, carry} : {{DIGIT_W{1'b0}}, carry};
  // reciprocal multiply, exact for every sum below 2^14
  assign prod = PROD_W'(sum) * PROD_W'(RECIP_MULT);
  assign quot = prod[RECIP_SHIFT +: BYTE_W];

  // quotient times 58 as 64 - 4 - 2
  assign quot_ext = SUM_W'(quot);
  assign quot_x58 = (quot_ext << 6) - (quot_ext << 2) - (quot_ext << 1);
  assign rem_full = sum - quot_x58;

  assign res.quot = quot;
  assign res.rem  = rem_full[DIGIT_W-1:0];

endmodule

FILE: sv/base58_encoder.sv
// base-58 encoder top level: sequencer, message counters and output register
//
//  channel | dir | tdata                     | tuser                         | tlast
//  --------+-----+---------------------------+-------------------------------+---------------
//  in_     | in  | [7:0] data_byte           | [0] has_byte                  | end_of_message
//  out_    | out | [6:0] character, [7] zero | [0] empty_message [1] too_long| last_char
//
// a byte is accepted, then each stored digit passes through the shared divide-by-58 unit,
// new digits are appended from the leftover carry, and the fold then finishes
// the end item passes through a finish step, then one character per cycle while the sink is ready
// reset clears control state only; the digit memory needs no clearing pass
// a stalled sink holds the output register and the sequencer waits on it
module base58_encoder #(
  parameter int MAX_BYTES  = b58_pkg::MAX_BYTES_DEF,
  parameter int MAX_DIGITS = b58_pkg::MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [0:0] in_tuser,   // [0] has_byte
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] character, [7] zero fill
  output logic [1:0] out_tuser,  // [0] empty_message, [1] too_long
  output logic       out_tlast   // last_char
);
  import b58_pkg::*;

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int DC_W  = $clog2(MAX_DIGITS + 1);
  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int MX_W  = (CNT_W > DC_W) ? CNT_W : DC_W;
  localparam int TOT_W = ((MX_W > OUT_LIMIT_W) ? MX_W : OUT_LIMIT_W) + 1;

  state_t state_r, state_nxt;

  // fold datapath
  logic [BYTE_W-1:0] carry_r, carry_nxt;
  logic [DC_W-1:0]   j_r, j_nxt;
  logic              end_r, end_nxt;

  // message counters
  logic [DC_W-1:0]  dc_r, dc_nxt;
  logic [CNT_W-1:0] lzc_r, lzc_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic             seen_r, seen_nxt;
  logic             ovf_r, ovf_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_r, out_empty_nxt;
  logic              out_long_r, out_long_nxt;

  // digit memory and shared unit
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DIGIT_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;
  fold_res_t          fres;

  logic             accept;
  logic             can_load;
  logic             in_range;
  logic             dc_full;
  logic             carry_zero;
  logic             fold_done;
  logic             byte_ok;
  logic             is_lead_zero;
  logic             do_fold;
  logic [TOT_W-1:0] tot;
  logic             ovf_all;
  logic [DC_W-1:0]  dc_m1;
  logic [DC_W-1:0]  j_m1;
  logic [DC_W-1:0]  j_p1;
  logic             clear_msg;

  b58_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  b58_fold_unit u_fold (
    .carry     (carry_r),
    .digit     (ram_rdata),
    .use_digit (in_range),
    .res       (fres)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign can_load  = !out_valid_r || out_tready;

  assign in_range     = (j_r < dc_r);
  assign dc_full      = (dc_r == DC_W'(MAX_DIGITS));
  assign carry_zero   = (carry_r == '0);
  // nothing left to fold: carry spent, or no room for another digit
  assign fold_done    = !in_range && (carry_zero || dc_full);
  assign byte_ok      = (bc_r < CNT_W'(MAX_BYTES));
  assign is_lead_zero = !seen_r && (in_tdata == '0);
  assign do_fold      = in_tuser[0] && byte_ok && !is_lead_zero && !ovf_r;

  // ones plus digits must fit the output length limit
  assign tot     = TOT_W'(lzc_r) + TOT_W'(dc_r);
  assign ovf_all = ovf_r || (tot > TOT_W'(OUT_LIMIT));

  assign dc_m1 = dc_r - 1'b1;
  assign j_m1  = j_r - 1'b1;
  assign j_p1  = j_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (do_fold)       state_nxt = S_FOLD;
          else if (in_tlast) state_nxt = S_FINISH;
        end
      end
      S_FOLD: begin
        if (fold_done) state_nxt = end_r ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (ovf_all || bc_r == '0) state_nxt = S_FLAG;
        else if (lzc_r != '0)      state_nxt = S_ZEROS;
        else                       state_nxt = S_DIGITS;
      end
      S_FLAG: begin
        if (can_load) state_nxt = S_IDLE;
      end
      S_ZEROS: begin
        if (can_load && lzc_r == CNT_W'(1)) begin
          state_nxt = (dc_r == '0) ? S_IDLE : S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (can_load && j_r == '0) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory control and output register
  always_comb begin
    carry_nxt     = carry_r;
    j_nxt         = j_r;
    end_nxt       = end_r;
    dc_nxt        = dc_r;
    lzc_nxt       = lzc_r;
    bc_nxt        = bc_r;
    seen_nxt      = seen_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_long_nxt  = out_long_r;
    ram_we        = 1'b0;
    ram_waddr     = j_r[AW-1:0];
    ram_wdata     = fres.rem;
    ram_raddr     = '0;
    clear_msg     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // digit 0 is prefetched so a fold starts at once
        if (accept) begin
          if (in_tuser[0]) begin
            if (!byte_ok) begin
              ovf_nxt = 1'b1;
            end else begin
              bc_nxt = bc_r + 1'b1;
              if (is_lead_zero) lzc_nxt = lzc_r + 1'b1;
              else              seen_nxt = 1'b1;
            end
          end
          if (do_fold) begin
            carry_nxt = in_tdata;
            j_nxt     = '0;
            end_nxt   = in_tlast;
          end
        end
      end
      S_FOLD: begin
        if (in_range) begin
          // rewrite digit j, prefetch digit j+1
          ram_we    = 1'b1;
          carry_nxt = fres.quot;
          j_nxt     = j_p1;
          if (j_p1 < dc_r) ram_raddr = j_p1[AW-1:0];
        end else if (!carry_zero) begin
          if (dc_full) begin
            ovf_nxt = 1'b1;
          end else begin
            // append a new top digit from the leftover carry
            ram_we    = 1'b1;
            ram_waddr = dc_r[AW-1:0];
            carry_nxt = fres.quot;
            dc_nxt    = dc_r + 1'b1;
            j_nxt     = j_p1;
          end
        end
      end
      S_FINISH: begin
        ovf_nxt   = ovf_all;
        ram_raddr = dc_m1[AW-1:0];
        j_nxt     = dc_m1;
      end
      S_FLAG: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_NONE;
          out_last_nxt  = 1'b1;
          out_empty_nxt = !ovf_r;
          out_long_nxt  = ovf_r;
          clear_msg     = 1'b1;
        end
      end
      S_ZEROS: begin
        // keep the top digit prefetched for the digit phase
        ram_raddr = dc_m1[AW-1:0];
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ONE;
          out_last_nxt  = (lzc_r == CNT_W'(1)) && (dc_r == '0);
          out_empty_nxt = 1'b0;
          out_long_nxt  = 1'b0;
          lzc_nxt       = lzc_r - 1'b1;
          if (lzc_r == CNT_W'(1) && dc_r == '0) clear_msg = 1'b1;
        end
      end
      S_DIGITS: begin
        // read data always belongs to digit j; re-read it while stalled
        ram_raddr = can_load ? j_m1[AW-1:0] : j_r[AW-1:0];
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = b58_char(ram_rdata);
          out_last_nxt  = (j_r == '0);
          out_empty_nxt = 1'b0;
          out_long_nxt  = 1'b0;
          if (j_r == '0) clear_msg = 1'b1;
          else           j_nxt = j_m1;
        end
      end
      default: begin
        ram_raddr = '0;
      end
    endcase

    if (clear_msg) begin
      dc_nxt   = '0;
      lzc_nxt  = '0;
      bc_nxt   = '0;
      seen_nxt = 1'b0;
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dc_r        <= '0;
      lzc_r       <= '0;
      bc_r        <= '0;
      seen_r      <= 1'b0;
      ovf_r       <= 1'b0;
      end_r       <= 1'b0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dc_r        <= dc_nxt;
      lzc_r       <= lzc_nxt;
      bc_r        <= bc_nxt;
      seen_r      <= seen_nxt;
      ovf_r       <= ovf_nxt;
      end_r       <= end_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    carry_r     <= carry_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_long_r  <= out_long_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tuser  = {out_long_r, out_empty_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: sv/b58_checker.sv
// port-level checks of the base-58 encoder and their bind
module b58_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // reset leaves no item pending and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // an end item starts work, so the input closes at once
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after an end item");

  // flagged results are single, final and carry no character
  a_flag_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'b00 |->
      out_tlast && out_tdata == 8'h00 && out_tuser != 2'b11)
    else $error("malformed flagged result");

  // plain characters come from the alphabet range
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'b00 |-> out_tdata >= 8'h31 && out_tdata <= 8'h7A)
    else $error("character outside the alphabet");

endmodule

bind base58_encoder b58_checker u_b58_checker (.*);

FILE: bench/base58_checker.sv
// checker for the base-58 encoder: predicts each message's text and compares every result
module base58_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [0:0] in_tuser,   // [0] has_byte
  input  logic       in_tlast,   // end_of_message
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [6:0] character, [7] zero fill
  input  logic [1:0] out_tuser,  // [0] empty_message, [1] too_long
  input  logic       out_tlast,  // last_char
  output int         mismatches,
  output int         awaited
);
  timeunit 1ns;
  timeprecision 1ps;
  import b58_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              final_char;
    logic              no_bytes;
    logic              overlong;
  } text_char_t;

  string glyphs = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // message state, digits least significant first
  logic [DIGIT_W-1:0] digits [MAX_DIGITS_DEF];
  int unsigned n_digits;
  int unsigned n_lead_zeros;
  int unsigned n_bytes;
  bit          nonzero_seen;
  bit          spoilt;

  text_char_t expected_text[$];
  int         fail_tally = 0;

  assign mismatches = fail_tally;

  function automatic void clear_message();
    for (int k = 0; k < MAX_DIGITS_DEF; k++) digits[k] = '0;
    n_digits     = 0;
    n_lead_zeros = 0;
    n_bytes      = 0;
    nonzero_seen = 1'b0;
    spoilt       = 1'b0;
  endfunction

  // multiply the stored number by 256 and add the byte
  function automatic void fold_byte(input int unsigned value);
    int unsigned carry;
    int unsigned j;
    carry = value;
    for (j = 0; j < n_digits; j++) begin
      carry = carry + int'(digits[j]) * 256;
      digits[j] = DIGIT_W'(carry % RADIX);
      carry = carry / RADIX;
    end
    while (carry > 0) begin
      if (n_digits >= MAX_DIGITS_DEF) begin
        spoilt = 1'b1;
        break;
      end
      digits[n_digits] = DIGIT_W'(carry % RADIX);
      n_digits++;
      carry = carry / RADIX;
    end
  endfunction

  function automatic void encode_item(input logic [7:0] value, input logic has, input logic last);
    int unsigned total;
    int unsigned i;
    logic [DIGIT_W-1:0] d;
    logic [7:0] g;
    if (has) begin
      if (n_bytes >= MAX_BYTES_DEF) begin
        spoilt = 1'b1;
      end else begin
        n_bytes++;
        if (!nonzero_seen && value == 8'h00) begin
          n_lead_zeros++;
        end else begin
          nonzero_seen = 1'b1;
          if (!spoilt) fold_byte(value);
        end
      end
    end
    if (!last) return;
    if (!spoilt && n_lead_zeros + n_digits > OUT_LIMIT) spoilt = 1'b1;
    if (spoilt) begin
      expected_text.push_back({CHAR_NONE, 1'b1, 1'b0, 1'b1});
    end else if (n_bytes == 0) begin
      expected_text.push_back({CHAR_NONE, 1'b1, 1'b1, 1'b0});
    end else begin
      total = n_lead_zeros + n_digits;
      for (i = 0; i < n_lead_zeros; i++)
        expected_text.push_back({CHAR_ONE, 1'(i + 1 == total), 1'b0, 1'b0});
      for (i = 0; i < n_digits; i++) begin
        d = digits[n_digits - 1 - i];
        g = glyphs[d];
        expected_text.push_back({g[CHAR_W-1:0], 1'(n_lead_zeros + i + 1 == total), 1'b0, 1'b0});
      end
    end
    clear_message();
  endfunction

  task automatic check_char();
    text_char_t want;
    if (expected_text.size() == 0) begin
      fail_tally++;
      $display("%0t: unexpected result: tdata %h tuser %b tlast %b",
               $time, out_tdata, out_tuser, out_tlast);
    end else begin
      want = expected_text.pop_front();
      if (out_tdata[6:0] !== want.glyph || out_tdata[7] !== 1'b0 ||
          out_tlast !== want.final_char || out_tuser[0] !== want.no_bytes ||
          out_tuser[1] !== want.overlong) begin
        fail_tally++;
        $display("%0t: mismatch: expected char %h fill 0 last %b empty %b too_long %b",
                 $time, want.glyph, want.final_char, want.no_bytes, want.overlong);
        $display("%0t:           actual   char %h fill %b last %b empty %b too_long %b",
                 $time, out_tdata[6:0], out_tdata[7], out_tlast, out_tuser[0], out_tuser[1]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_message();
      expected_text.delete();
    end else begin
      if (out_tvalid && out_tready) check_char();
      if (in_tvalid && in_tready) encode_item(in_tdata, in_tuser[0], in_tlast);
    end
    awaited <= expected_text.size();
  end

endmodule

FILE: bench/testbench.sv
// top of the base-58 encoder testbench: clock, reset, message stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import b58_pkg::*;

  localparam int ITEM_TARGET   = 210;     // items that carry a byte or an end mark
  localparam int CALM_FROM     = 170;     // from here on neither side idles
  localparam int HOLD_CYCLES   = 200;     // long sink hold-off to back the block up
  localparam int SETTLE_CYCLES = 100;     // well past one byte's fold time
  localparam int DRAIN_LIMIT   = 200000;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] data_byte
  logic [0:0] in_tuser   = 1'b0;   // [0] has_byte
  logic       in_tlast   = 1'b0;   // end_of_message
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [6:0] character, [7] zero fill
  logic [1:0] out_tuser;           // [0] empty_message, [1] too_long
  logic       out_tlast;           // last_char

  int mismatches;
  int awaited;
  int items_sent = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  base58_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  base58_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // offer one item, optionally after a short gap, and hold it until accepted
  task automatic send_item(input logic [7:0] value, input bit has, input bit last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = value;
    in_tuser  = has;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (has || last) items_sent++;
    calm = (items_sent >= CALM_FROM);
  endtask

  // one message: leading zeros, then random bytes, with stray byte-less items mixed in
  task automatic send_message(input int len, input int zeros, input bit separate_end,
                              input bit saturate);
    logic [7:0] value;
    for (int i = 0; i < len; i++) begin
      // an item with no byte and no end mark is simply skipped by the block
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (i < zeros) begin
        value = 8'h00;
      end else if (saturate) begin
        value = 8'hFF;
      end else begin
        case ($urandom_range(0, 7))
          0: value = 8'hFF;
          1: value = 8'h00;
          default: value = 8'($urandom_range(0, 255));
        endcase
      end
      send_item(value, 1'b1, !separate_end && i == len - 1);
    end
    // end marker without a byte, its data bits are don't-care
    if (separate_end || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // sink side: random short stalls, one long hold-off, none in the calm tail
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done  = 1'b1;
        out_tready = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // hard stop should anything hang
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int msg;
    int pick;
    int len;
    int zeros;
    int drain_cycles;

    // hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty message
    send_item(8'h00, 1'b0, 1'b1);
    // a lone zero byte, then an all-zero message
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    // top byte, exact radix and one below it
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h3A, 1'b1, 1'b1);
    send_item(8'h39, 1'b1, 1'b1);
    // leading zeros ahead of a nonzero byte
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b1);
    // byte, an ignored item, then a separate end marker
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'hAA, 1'b0, 1'b1);
    // a zero after a nonzero byte is a real digit, not a leading zero
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    // several saturated bytes so the digit store grows
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);

    // let everything drain before the random part
    in_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk);

    // random messages; the sink starts with its long hold-off so the block backs up
    hold_req = 1'b1;
    msg = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (msg == 2 || (msg > 5 && pick < 6)) begin
        len = MAX_BYTES_DEF + $urandom_range(1, 4);    // overlong message
      end else if (msg == 5 || pick < 10) begin
        len = MAX_BYTES_DEF;                            // longest that still encodes
      end else if (pick < 18) begin
        len = 0;                                        // empty message
      end else begin
        len = $urandom_range(1, 8);
      end
      zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : 0;
      send_message(len, zeros, $urandom_range(0, 3) == 0, msg == 5);
      msg++;
    end
    in_tvalid = 1'b0;

    // wait for the last characters, then give the block time to misbehave
    drain_cycles = 0;
    while (awaited != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (awaited != 0) $display("%0t: %0d results never arrived", $time, awaited);
    if (mismatches == 0 && awaited == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/b58_pkg.sv
sv/b58_ram.sv
sv/b58_fold_unit.sv
sv/base58_encoder.sv
sv/b58_checker.sv
bench/base58_checker.sv
bench/testbench.sv
